FILE: design/ccbm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the copier cartridge bank mapper
// no dependencies; used by ccbm_prg_map and copier_cart_bank_mapper_with_irq
package ccbm_pkg;

   // cpu register addresses
   localparam logic [15:0] ADDR_IRQ_ACK   = 16'h4024;
   localparam logic [15:0] ADDR_DIV_CTRL  = 16'h4025;
   localparam logic [15:0] ADDR_UPDN_LO   = 16'h4100;
   localparam logic [15:0] ADDR_UPDN_HI   = 16'h4101;
   localparam logic [15:0] ADDR_MODE      = 16'h42FC;
   localparam logic [15:0] ADDR_MODE_FOUR = 16'h43FC;
   localparam logic [15:0] ADDR_SUB_MASK  = 16'hFFFC;

   localparam logic [7:0]  DIV_CLEAR_MASK = 8'h42;
   localparam logic [14:0] DIV_MAX        = 15'h7FFF;
   localparam int          DIVIDER_PERIOD_DEF = 448;

   // register file index of the config port
   localparam logic CSR_POWER_MODE     = 1'b0;
   localparam logic CSR_POWER_VERTICAL = 1'b1;

   // item kinds
   localparam logic ITEM_WRITE = 1'b0;
   localparam logic ITEM_TICK  = 1'b1;

   typedef enum logic [2:0] {
      BM_PAIR_LOW    = 3'd0,
      BM_PAIR_MID    = 3'd1,
      BM_PAIR_HIGH   = 3'd2,
      BM_HIGH_SWITCH = 3'd3,
      BM_QUAD        = 3'd4,
      BM_QUAD_FIXED  = 3'd5,
      BM_SPLIT       = 3'd6,
      BM_SPLIT_ODD   = 3'd7
   } bank_mode_type;

   typedef logic [3:0][5:0] prg_banks_type;

   localparam prg_banks_type PRG_RESET = {6'h1F, 6'h1E, 6'h1D, 6'h1C};

   typedef struct packed {
      logic [7:0]    mode_reg;
      logic [7:0]    mode_four_reg;
      logic [7:0]    latch;
      prg_banks_type prg;
   } map_state_type;

   function automatic logic [7:0] power_mode_value(input logic [2:0] pmode,
                                                   input logic vertical);
      return {pmode, vertical ? 5'h03 : 5'h13};
   endfunction

endpackage

FILE: design/ccbm_prg_map.sv
`timescale 1ns / 1ps
// prg bank mapping: turns mode, mode-four, latch and prg registers into four 8KB banks
// depends on ccbm_pkg
module ccbm_prg_map (
   input  ccbm_pkg::map_state_type st,
   output ccbm_pkg::prg_banks_type banks
);
   import ccbm_pkg::*;

   logic [7:0] l;

   assign l = st.latch;

   always_comb begin
      banks = st.prg;
      if (st.mode_four_reg[0]) begin
         banks[2] = 6'd14;
         banks[3] = 6'd15;
         case (bank_mode_type'(st.mode_reg[7:5]))
            BM_PAIR_LOW: begin
               banks[0] = {2'b00, l[2:0], 1'b0};
               banks[1] = {2'b00, l[2:0], 1'b1};
            end
            BM_PAIR_MID: begin
               banks[0] = {1'b0, l[5:2], 1'b0};
               banks[1] = {1'b0, l[5:2], 1'b1};
            end
            BM_PAIR_HIGH: begin
               banks[0] = {1'b0, l[3:0], 1'b0};
               banks[1] = {1'b0, l[3:0], 1'b1};
               banks[2] = 6'd30;
               banks[3] = 6'd31;
            end
            BM_HIGH_SWITCH: begin
               banks[0] = 6'd30;
               banks[1] = 6'd31;
               banks[2] = {1'b0, l[3:0], 1'b0};
               banks[3] = {1'b0, l[3:0], 1'b1};
            end
            BM_QUAD: begin
               banks[0] = {2'b00, l[5:4], 2'd0};
               banks[1] = {2'b00, l[5:4], 2'd1};
               banks[2] = {2'b00, l[5:4], 2'd2};
               banks[3] = {2'b00, l[5:4], 2'd3};
            end
            BM_QUAD_FIXED: begin
               banks[0] = 6'd12;
               banks[1] = 6'd13;
               banks[2] = 6'd14;
               banks[3] = 6'd15;
            end
            BM_SPLIT: begin
               banks[0] = {2'b00, l[3:0]};
               banks[1] = {2'b00, l[7:4]};
            end
            default: begin
               banks[0] = {2'b00, l[3:1], 1'b0};
               banks[1] = {2'b00, l[7:5], 1'b1};
            end
         endcase
      end
   end

endmodule

FILE: design/copier_cart_bank_mapper_with_irq.sv
`timescale 1ns / 1ps
// top level of the copier cartridge bank mapper with divider and up-counter irq
// depends on ccbm_pkg and ccbm_prg_map
//
// usage:
//   req channel carries one item per transfer: a cpu write (req_mode 0, address
//   and data) or a tick of cpu cycles (req_mode 1, req_cycles).
//   rsp channel returns exactly one result per item: the four 8KB prg banks,
//   chr bank, mirroring, write enables, memory write pass-through and irq level
//   as they stand after that item.
//   the apb port holds the power-up straps (mode at 0x0, vertical at 0x4);
//   writing one reloads the mode register from the straps. write it only idle.
// timing:
//   an item is held in the input register; the whole decode, counter update
//   and bank mapping runs combinationally from it into the result register,
//   which drives rsp_valid. one item per cycle is sustained while rsp_ready
//   stays high; the bound is the state update loop.
//   while rsp_ready is low the result is held and one more item is taken into
//   the input register, then req_ready drops until the result moves on.
//   reset (synchronous) empties both registers and loads the power-up state.
module copier_cart_bank_mapper_with_irq #(
   parameter int DIVIDER_PERIOD = ccbm_pkg::DIVIDER_PERIOD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   input  logic [7:0]  req_cycles,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_prg_bank_8000,
   output logic [5:0]  rsp_prg_bank_a000,
   output logic [5:0]  rsp_prg_bank_c000,
   output logic [5:0]  rsp_prg_bank_e000,
   output logic [1:0]  rsp_chr_bank,
   output logic [1:0]  rsp_mirroring,
   output logic        rsp_prg_writable,
   output logic        rsp_chr_writable,
   output logic        rsp_memory_write,
   output logic        rsp_irq_line,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ccbm_pkg::*;

   localparam int MOD_W = $clog2(DIVIDER_PERIOD + 1);
   localparam logic [MOD_W-1:0] SAT_MOD = MOD_W'(32767 % DIVIDER_PERIOD);
   localparam logic [MOD_W:0]   PERIOD_M = (MOD_W + 1)'(DIVIDER_PERIOD);
   localparam logic [14:0]      PERIOD_C = 15'(DIVIDER_PERIOD);

   // (3 * cycles) mod period for every cycles value
   function automatic logic [256*MOD_W-1:0] build_mod_tbl(input int p);
      logic [256*MOD_W-1:0] t;
      int r;
      t = '0;
      r = 0;
      for (int c = 0; c < 256; c++) begin
         t[c*MOD_W +: MOD_W] = MOD_W'(r);
         r = r + 3;
         for (int k = 0; k < 3; k++) begin
            if (r >= p) r = r - p;
         end
      end
      return t;
   endfunction

   localparam logic [256*MOD_W-1:0] MOD_TBL = build_mod_tbl(DIVIDER_PERIOD);

   // handshake and item registers
   logic        in_valid_ff, in_valid_in;
   logic        item_mode_ff;
   logic [15:0] item_addr_ff;
   logic [7:0]  item_data_ff;
   logic [7:0]  item_cycles_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        advance;
   logic        req_xfer;

   // straps
   logic [2:0]  power_mode_ff, power_mode_in;
   logic        power_vert_ff, power_vert_in;
   logic        cfg_write;

   // mapper state
   logic [7:0]       mode_reg_ff, mode_reg_in;
   logic [7:0]       mode_four_ff, mode_four_in;
   logic [7:0]       latch_ff, latch_in;
   prg_banks_type    prg_ff, prg_in;
   logic [1:0]       chr_ff, chr_in;
   logic [7:0]       div_ctrl_ff, div_ctrl_in;
   logic [14:0]      div_cnt_ff, div_cnt_in;
   logic [MOD_W-1:0] div_mod_ff, div_mod_in;
   logic [15:0]      updn_ff, updn_in;
   logic             irq_ff, irq_in;
   logic             mem_wr;

   // tick arithmetic
   logic [15:0]      div_sum;
   logic [MOD_W:0]   mod_sum;
   logic [MOD_W-1:0] mod_step;
   logic [14:0]      cnt_sat;
   logic [MOD_W-1:0] mod_sat;
   logic [15:0]      updn_sum;

   map_state_type    map_st;
   prg_banks_type    banks;

   // result registers
   prg_banks_type rsp_banks_ff;
   logic [1:0]    rsp_chr_ff;
   logic [1:0]    rsp_mirr_ff;
   logic          rsp_prg_we_ff;
   logic          rsp_chr_we_ff;
   logic          rsp_mem_wr_ff;
   logic          rsp_irq_ff;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign req_xfer     = req_valid && req_ready;
   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      power_mode_in = power_mode_ff;
      power_vert_in = power_vert_ff;
      case (paddr[2])
         CSR_POWER_MODE:     power_mode_in = pwdata[2:0];
         CSR_POWER_VERTICAL: power_vert_in = pwdata[0];
         default:            power_mode_in = power_mode_ff;
      endcase
   end

   always_comb begin
      case (paddr[2])
         CSR_POWER_MODE:     prdata = {29'd0, power_mode_ff};
         CSR_POWER_VERTICAL: prdata = {31'd0, power_vert_ff};
         default:            prdata = '0;
      endcase
   end

   // divider: count and its residue mod period are carried side by side
   assign div_sum  = {1'b0, div_cnt_ff} + {7'd0, item_cycles_ff, 1'b0}
                     + {8'd0, item_cycles_ff};
   assign mod_step = MOD_TBL[item_cycles_ff*MOD_W +: MOD_W];
   assign mod_sum  = {1'b0, div_mod_ff} + {1'b0, mod_step};
   assign cnt_sat  = div_sum[15] ? DIV_MAX : div_sum[14:0];
   assign mod_sat  = div_sum[15] ? SAT_MOD
                   : (mod_sum >= PERIOD_M) ? MOD_W'(mod_sum - PERIOD_M)
                   : mod_sum[MOD_W-1:0];
   assign updn_sum = updn_ff + {8'd0, item_cycles_ff};

   always_comb begin
      mode_reg_in  = mode_reg_ff;
      mode_four_in = mode_four_ff;
      latch_in     = latch_ff;
      prg_in       = prg_ff;
      chr_in       = chr_ff;
      div_ctrl_in  = div_ctrl_ff;
      div_cnt_in   = div_cnt_ff;
      div_mod_in   = div_mod_ff;
      updn_in      = updn_ff;
      irq_in       = irq_ff;
      mem_wr       = 1'b0;
      if (item_mode_ff == ITEM_TICK) begin
         div_cnt_in = cnt_sat;
         div_mod_in = mod_sat;
         if (div_ctrl_ff[7] && cnt_sat >= PERIOD_C) begin
            div_cnt_in = 15'(mod_sat);
            irq_in     = 1'b1;
         end
         if (updn_ff[15]) begin
            updn_in = updn_sum;
            if (!updn_sum[15]) irq_in = 1'b1;
         end
      end else if (item_addr_ff[15]) begin
         if (mode_reg_ff[1]) begin
            latch_in = item_data_ff;
            case (bank_mode_type'(mode_reg_ff[7:5]))
               BM_PAIR_LOW, BM_PAIR_HIGH:           chr_in = 2'd0;
               BM_PAIR_MID, BM_QUAD, BM_QUAD_FIXED: chr_in = item_data_ff[1:0];
               BM_HIGH_SWITCH:                      chr_in = item_data_ff[5:4];
               default:                             chr_in = chr_ff;
            endcase
            prg_in[item_addr_ff[14:13]] = item_data_ff[7:2];
         end else begin
            mem_wr = 1'b1;
         end
      end else if (item_addr_ff == ADDR_IRQ_ACK) begin
         irq_in = 1'b0;
      end else if (item_addr_ff == ADDR_DIV_CTRL) begin
         irq_in      = 1'b0;
         div_ctrl_in = item_data_ff;
         if ((item_data_ff & DIV_CLEAR_MASK) != 8'd0) begin
            div_cnt_in = '0;
            div_mod_in = '0;
         end
      end else if (item_addr_ff == ADDR_UPDN_LO) begin
         irq_in  = 1'b0;
         updn_in = (item_data_ff == 8'd0) ? 16'd0 : {updn_ff[15:8], item_data_ff};
      end else if (item_addr_ff == ADDR_UPDN_HI) begin
         irq_in  = 1'b0;
         updn_in = {item_data_ff, updn_ff[7:0]};
      end else if ((item_addr_ff & ADDR_SUB_MASK) == ADDR_MODE) begin
         mode_reg_in = {item_data_ff[7:4], 2'b00, item_addr_ff[1:0]};
      end else if ((item_addr_ff & ADDR_SUB_MASK) == ADDR_MODE_FOUR) begin
         mode_four_in = {item_data_ff[7:4], 2'b00, item_addr_ff[1:0]};
         chr_in       = item_data_ff[1:0];
      end
   end

   assign map_st = '{mode_reg: mode_reg_in, mode_four_reg: mode_four_in,
                     latch: latch_in, prg: prg_in};

   ccbm_prg_map u_prg_map (
      .st    (map_st),
      .banks (banks)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         power_mode_ff <= 3'd0;
         power_vert_ff <= 1'b1;
         mode_reg_ff   <= power_mode_value(3'd0, 1'b1);
         mode_four_ff  <= 8'd3;
         latch_ff      <= 8'd0;
         prg_ff        <= PRG_RESET;
         chr_ff        <= 2'd0;
         div_ctrl_ff   <= 8'd0;
         div_cnt_ff    <= 15'd0;
         div_mod_ff    <= '0;
         updn_ff       <= 16'd0;
         irq_ff        <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_write) begin
            power_mode_ff <= power_mode_in;
            power_vert_ff <= power_vert_in;
            mode_reg_ff   <= power_mode_value(power_mode_in, power_vert_in);
         end else if (advance) begin
            mode_reg_ff <= mode_reg_in;
         end
         if (advance) begin
            mode_four_ff <= mode_four_in;
            latch_ff     <= latch_in;
            prg_ff       <= prg_in;
            chr_ff       <= chr_in;
            div_ctrl_ff  <= div_ctrl_in;
            div_cnt_ff   <= div_cnt_in;
            div_mod_ff   <= div_mod_in;
            updn_ff      <= updn_in;
            irq_ff       <= irq_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_mode_ff   <= req_mode;
         item_addr_ff   <= req_address;
         item_data_ff   <= req_data;
         item_cycles_ff <= req_cycles;
      end
      if (advance) begin
         rsp_banks_ff  <= banks;
         rsp_chr_ff    <= chr_in;
         rsp_mirr_ff   <= {mode_reg_in[4], mode_reg_in[0]};
         rsp_prg_we_ff <= !mode_reg_in[1];
         rsp_chr_we_ff <= !mode_reg_in[7];
         rsp_mem_wr_ff <= mem_wr;
         rsp_irq_ff    <= irq_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_prg_bank_8000 = rsp_banks_ff[0];
   assign rsp_prg_bank_a000 = rsp_banks_ff[1];
   assign rsp_prg_bank_c000 = rsp_banks_ff[2];
   assign rsp_prg_bank_e000 = rsp_banks_ff[3];
   assign rsp_chr_bank      = rsp_chr_ff;
   assign rsp_mirroring     = rsp_mirr_ff;
   assign rsp_prg_writable  = rsp_prg_we_ff;
   assign rsp_chr_writable  = rsp_chr_we_ff;
   assign rsp_memory_write  = rsp_mem_wr_ff;
   assign rsp_irq_line      = rsp_irq_ff;

`ifndef SYNTHESIS
   // residue tracker never leaves its range
   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, div_mod_ff} < PERIOD_M)
      else $error("divider residue out of range");

   // pass-through writes only happen with prg writable
   a_memwr_we: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mem_wr_ff |-> rsp_prg_we_ff)
      else $error("memory write without prg write enable");

   // irq can only be raised by a tick item
   a_irq_source: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_ff) |-> $past(advance && item_mode_ff == ITEM_TICK))
      else $error("irq raised without a tick");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for copier_cart_bank_mapper_with_irq: cpu writes and cycle ticks
// against a local mapper model, with the power straps swept over the apb port
// depends on ccbm_pkg and the design sources
module tb_top;
   import ccbm_pkg::*;

   localparam int          DIV_PERIOD     = DIVIDER_PERIOD_DEF;
   localparam int          DIV_ENABLE     = 7;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          HOLDOFF_CYCLES = 80;
   localparam int          PHASE_ITEMS    = 160;
   localparam logic [15:0] ROM_BASE       = 16'h8000;

   typedef struct {
      logic        mode;
      logic [15:0] address;
      logic [7:0]  data;
      logic [7:0]  cycles;
   } bus_item_type;

   typedef struct {
      logic [5:0] bank_8000;
      logic [5:0] bank_a000;
      logic [5:0] bank_c000;
      logic [5:0] bank_e000;
      logic [1:0] chr;
      logic [1:0] mirroring;
      logic       prg_we;
      logic       chr_we;
      logic       mem_wr;
      logic       irq;
   } map_result_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic        req_mode    = ITEM_WRITE;
   logic [15:0] req_address = '0;
   logic [7:0]  req_data    = '0;
   logic [7:0]  req_cycles  = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [5:0]  rsp_prg_bank_8000;
   logic [5:0]  rsp_prg_bank_a000;
   logic [5:0]  rsp_prg_bank_c000;
   logic [5:0]  rsp_prg_bank_e000;
   logic [1:0]  rsp_chr_bank;
   logic [1:0]  rsp_mirroring;
   logic        rsp_prg_writable;
   logic        rsp_chr_writable;
   logic        rsp_memory_write;
   logic        rsp_irq_line;
   logic        psel        = 1'b0;
   logic        penable     = 1'b0;
   logic        pwrite      = 1'b0;
   logic [2:0]  paddr       = '0;
   logic [31:0] pwdata      = '0;
   logic [31:0] prdata;
   logic        pready;

   // mapper model state
   logic [2:0]  strap_mode;
   logic        strap_vertical;
   logic [7:0]  mode_reg;
   logic [7:0]  mode4_reg;
   logic [7:0]  latch;
   logic [5:0]  prg_reg [4];
   logic [1:0]  chr_reg;
   logic [7:0]  div_ctrl;
   int          div_count;
   logic [15:0] updn_count;
   logic        irq_level;

   bus_item_type   pending_items [$];
   map_result_type expected_maps [$];

   int   queued_count   = 0;
   int   accepted_count = 0;
   int   results_seen   = 0;
   int   error_count    = 0;
   int   irq_results    = 0;
   int   pass_through   = 0;
   int   strap_settings = 1;
   int   req_gap        = 0;
   int   rsp_gap        = 0;
   int   stall_left     = 0;
   int   quiet_cycles   = 0;
   logic idle_on        = 1'b1;
   logic stall_request  = 1'b0;
   logic stall_taken    = 1'b0;

   logic [2:0] phase_mode [8] = '{3'd7, 3'd0, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4};

   copier_cart_bank_mapper_with_irq #(
      .DIVIDER_PERIOD(DIV_PERIOD)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_address(req_address),
      .req_data(req_data),
      .req_cycles(req_cycles),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_prg_bank_8000(rsp_prg_bank_8000),
      .rsp_prg_bank_a000(rsp_prg_bank_a000),
      .rsp_prg_bank_c000(rsp_prg_bank_c000),
      .rsp_prg_bank_e000(rsp_prg_bank_e000),
      .rsp_chr_bank(rsp_chr_bank),
      .rsp_mirroring(rsp_mirroring),
      .rsp_prg_writable(rsp_prg_writable),
      .rsp_chr_writable(rsp_chr_writable),
      .rsp_memory_write(rsp_memory_write),
      .rsp_irq_line(rsp_irq_line),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] strap_mode_reg();
      return {strap_mode, ~strap_vertical, 4'b0011};
   endfunction

   // applies one bus item to the model and returns the mapping after it
   function automatic map_result_type step_mapper(bus_item_type it);
      map_result_type r;
      int             bank [4];
      int             x;
      logic [7:0]     v;
      r.mem_wr = 1'b0;
      v        = it.data;
      if (it.mode == ITEM_TICK) begin
         div_count = div_count + 3 * int'(it.cycles);
         if (div_count > int'(DIV_MAX))
            div_count = int'(DIV_MAX);
         if (div_ctrl[DIV_ENABLE] && div_count >= DIV_PERIOD) begin
            div_count = div_count % DIV_PERIOD;
            irq_level = 1'b1;
         end
         // up-counter only runs while negative
         if (updn_count[15]) begin
            updn_count = updn_count + {8'd0, it.cycles};
            if (!updn_count[15])
               irq_level = 1'b1;
         end
      end else if (it.address >= ROM_BASE) begin
         if (mode_reg[1]) begin
            latch = v;
            case (bank_mode_type'(mode_reg[7:5]))
               BM_PAIR_LOW, BM_PAIR_HIGH:         chr_reg = 2'd0;
               BM_PAIR_MID, BM_QUAD, BM_QUAD_FIXED: chr_reg = v[1:0];
               BM_HIGH_SWITCH:                    chr_reg = v[5:4];
               default: ;
            endcase
            prg_reg[it.address[14:13]] = v[7:2];
         end else begin
            r.mem_wr = 1'b1;
         end
      end else if (it.address == ADDR_IRQ_ACK) begin
         irq_level = 1'b0;
      end else if (it.address == ADDR_DIV_CTRL) begin
         irq_level = 1'b0;
         div_ctrl  = v;
         if ((v & DIV_CLEAR_MASK) != 8'd0)
            div_count = 0;
      end else if (it.address == ADDR_UPDN_LO) begin
         irq_level  = 1'b0;
         updn_count = {updn_count[15:8], v};
         if (v == 8'd0)
            updn_count = '0;
      end else if (it.address == ADDR_UPDN_HI) begin
         irq_level  = 1'b0;
         updn_count = {v, updn_count[7:0]};
      end else if ((it.address & ADDR_SUB_MASK) == ADDR_MODE) begin
         mode_reg = {v[7:4], 2'b00, it.address[1:0]};
      end else if ((it.address & ADDR_SUB_MASK) == ADDR_MODE_FOUR) begin
         mode4_reg = {v[7:4], 2'b00, it.address[1:0]};
         chr_reg   = v[1:0];
      end

      if (!mode4_reg[0]) begin
         for (int i = 0; i < 4; i++)
            bank[i] = int'(prg_reg[i]);
      end else begin
         bank[2] = 14;
         bank[3] = 15;
         case (bank_mode_type'(mode_reg[7:5]))
            BM_PAIR_LOW: begin
               x = int'(latch[2:0]);
               bank[0] = 2 * x;
               bank[1] = 2 * x + 1;
            end
            BM_PAIR_MID: begin
               x = int'(latch[5:2]);
               bank[0] = 2 * x;
               bank[1] = 2 * x + 1;
            end
            BM_PAIR_HIGH: begin
               x = int'(latch[3:0]);
               bank[0] = 2 * x;
               bank[1] = 2 * x + 1;
               bank[2] = 30;
               bank[3] = 31;
            end
            BM_HIGH_SWITCH: begin
               x = int'(latch[3:0]);
               bank[0] = 30;
               bank[1] = 31;
               bank[2] = 2 * x;
               bank[3] = 2 * x + 1;
            end
            BM_QUAD: begin
               x = int'(latch[5:4]);
               for (int i = 0; i < 4; i++)
                  bank[i] = 4 * x + i;
            end
            BM_QUAD_FIXED: begin
               for (int i = 0; i < 4; i++)
                  bank[i] = 12 + i;
            end
            BM_SPLIT: begin
               bank[0] = int'(latch[3:0]);
               bank[1] = int'(latch[7:4]);
            end
            default: begin
               bank[0] = int'(latch[3:0] & 4'hE);
               bank[1] = int'(latch[7:4] | 4'h1);
            end
         endcase
      end

      r.bank_8000 = 6'(bank[0]);
      r.bank_a000 = 6'(bank[1]);
      r.bank_c000 = 6'(bank[2]);
      r.bank_e000 = 6'(bank[3]);
      r.chr       = chr_reg;
      r.mirroring = {mode_reg[4], mode_reg[0]};
      r.prg_we    = ~mode_reg[1];
      r.chr_we    = ~mode_reg[7];
      r.irq       = irq_level;
      return r;
   endfunction

   function automatic void queue_write(logic [15:0] a, logic [7:0] d);
      bus_item_type it;
      it = '{ITEM_WRITE, a, d, 8'($urandom)};
      pending_items.push_back(it);
      queued_count++;
   endfunction

   function automatic void queue_tick(logic [7:0] c);
      bus_item_type it;
      it = '{ITEM_TICK, 16'($urandom), 8'($urandom), c};
      pending_items.push_back(it);
      queued_count++;
   endfunction

   task automatic flag_error(string msg);
      error_count++;
      $display("[%0t] error: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         flag_error($sformatf("result %0d %s got 0x%0h want 0x%0h",
                              results_seen, name, got, want));
   endtask

   // strap write followed by a read-back; only called with the block idle
   task automatic write_strap(logic idx, logic [2:0] value);
      logic [31:0] want;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {29'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == CSR_POWER_MODE)
         strap_mode = value;
      else
         strap_vertical = value[0];
      mode_reg = strap_mode_reg();
      want     = (idx == CSR_POWER_MODE) ? {29'd0, value} : {31'd0, value[0]};
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want)
         flag_error($sformatf("strap %0d read back 0x%0h want 0x%0h", idx, prdata, want));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_for_drain();
      do
         @(posedge clock);
      while (accepted_count != queued_count || expected_maps.size() != 0);
      // two-stage pipeline, leave some margin
      repeat (4) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      bus_item_type   nxt;
      map_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            nxt  = '{req_mode, req_address, req_data, req_cycles};
            want = step_mapper(nxt);
            expected_maps.push_back(want);
            accepted_count++;
            irq_results  += int'(want.irq);
            pass_through += int'(want.mem_wr);
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               nxt = pending_items.pop_front();
               req_valid   <= 1'b1;
               req_mode    <= nxt.mode;
               req_address <= nxt.address;
               req_data    <= nxt.data;
               req_cycles  <= nxt.cycles;
               if (idle_on && $urandom_range(0, 9) == 0)
                  req_gap = $urandom_range(1, 17);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      map_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_maps.size() == 0) begin
               flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want = expected_maps.pop_front();
               check_field("prg_bank_8000", 8'(rsp_prg_bank_8000), 8'(want.bank_8000));
               check_field("prg_bank_a000", 8'(rsp_prg_bank_a000), 8'(want.bank_a000));
               check_field("prg_bank_c000", 8'(rsp_prg_bank_c000), 8'(want.bank_c000));
               check_field("prg_bank_e000", 8'(rsp_prg_bank_e000), 8'(want.bank_e000));
               check_field("chr_bank", 8'(rsp_chr_bank), 8'(want.chr));
               check_field("mirroring", 8'(rsp_mirroring), 8'(want.mirroring));
               check_field("prg_writable", 8'(rsp_prg_writable), 8'(want.prg_we));
               check_field("chr_writable", 8'(rsp_chr_writable), 8'(want.chr_we));
               check_field("memory_write", 8'(rsp_memory_write), 8'(want.mem_wr));
               check_field("irq_line", 8'(rsp_irq_line), 8'(want.irq));
            end
            results_seen++;
         end
         if (stall_request && !stall_taken) begin
            stall_left  = HOLDOFF_CYCLES;
            stall_taken = 1'b1;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 11) == 0)
               rsp_gap = $urandom_range(1, 17);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_maps.size());
            $display("copier_cart_bank_mapper_with_irq verification failed");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      int target;
      strap_mode     = 3'd0;
      strap_vertical = 1'b1;
      mode_reg       = strap_mode_reg();
      mode4_reg      = 8'h03;
      latch          = '0;
      prg_reg        = '{6'h1C, 6'h1D, 6'h1E, 6'h1F};
      chr_reg        = '0;
      div_ctrl       = '0;
      div_count      = 0;
      updn_count     = '0;
      irq_level      = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed items under the reset straps
      queue_tick(8'h00);
      queue_write(ROM_BASE, 8'hFF);
      queue_write(16'hFFFF, 8'h00);
      queue_write(ADDR_MODE, 8'hF0);                // latch write-protected, chr locked
      queue_write(16'hC000, 8'h5A);                 // goes to prg memory
      queue_write(ADDR_MODE | 16'd3, 8'h6F);
      queue_write(ADDR_MODE_FOUR, 8'hFF);           // direct prg registers, chr 3
      queue_write(16'hA000, 8'hAB);
      queue_write(16'hE000, 8'h7C);
      queue_write(ADDR_MODE_FOUR | 16'd1, 8'h00);
      queue_write(ADDR_DIV_CTRL, 8'h80);
      queue_tick(8'hFF);                            // divider passes its period
      queue_write(ADDR_IRQ_ACK, 8'h00);
      queue_write(ADDR_DIV_CTRL, 8'hC2);            // clear bits set
      queue_write(ADDR_UPDN_LO, 8'h00);             // zero low byte clears the counter
      queue_write(ADDR_UPDN_HI, 8'hFF);
      queue_write(ADDR_UPDN_LO, 8'hF0);
      queue_tick(8'h10);                            // up-counter crosses zero
      queue_write(ADDR_UPDN_HI, 8'h80);
      queue_write(16'h0000, 8'hAA);
      queue_write(ADDR_DIV_CTRL + 16'd1, 8'h55);
      queue_write(ADDR_DIV_CTRL, 8'h00);
      queue_tick(8'h01);
      queue_write(ADDR_UPDN_LO, 8'h01);
      wait_for_drain();

      for (int p = 0; p < 8; p++) begin
         write_strap(CSR_POWER_MODE, phase_mode[p]);
         write_strap(CSR_POWER_VERTICAL, {2'b00, p[0]});
         strap_settings++;
         idle_on = !(p == 4 || p == 7);
         if (p == 2)
            stall_request = 1'b1;
         target = queued_count + PHASE_ITEMS;
         while (queued_count < target) begin
            pick = $urandom_range(0, 39);
            if (pick < 14) begin
               // bank programming, sometimes with a new mode first
               if ($urandom_range(0, 3) == 0)
                  queue_write(ADDR_MODE | 16'($urandom_range(0, 3)), 8'($urandom));
               if ($urandom_range(0, 5) == 0)
                  queue_write(ADDR_MODE_FOUR | 16'($urandom_range(0, 3)), 8'($urandom));
               repeat ($urandom_range(2, 6))
                  queue_write(ROM_BASE | 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
            end else if (pick < 23) begin
               // arm the up-counter near zero and tick through it
               queue_write(ADDR_UPDN_LO,
                           ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
               case ($urandom_range(0, 3))
                  0: queue_write(ADDR_UPDN_HI, 8'hFF);
                  1: queue_write(ADDR_UPDN_HI, 8'hFE);
                  2: queue_write(ADDR_UPDN_HI, 8'h80 | 8'($urandom));
                  default: queue_write(ADDR_UPDN_HI, 8'($urandom));
               endcase
               repeat ($urandom_range(1, 5))
                  queue_tick(8'($urandom_range(0, 60)));
               if ($urandom_range(0, 1) == 0)
                  queue_write(ADDR_IRQ_ACK, 8'($urandom));
            end else if (pick < 31) begin
               // divider runs
               queue_write(ADDR_DIV_CTRL, ($urandom_range(0, 3) != 0) ?
                           (8'h80 | 8'($urandom)) : 8'($urandom));
               repeat ($urandom_range(1, 6))
                  queue_tick(8'($urandom));
               if ($urandom_range(0, 2) == 0)
                  queue_write(ADDR_IRQ_ACK, 8'($urandom));
            end else if (pick == 31 && $urandom_range(0, 3) == 0) begin
               // let the disabled divider saturate, then enable it without clearing
               queue_write(ADDR_DIV_CTRL, 8'($urandom) & 8'h7F);
               repeat (45) queue_tick(8'hFF);
               queue_write(ADDR_DIV_CTRL, 8'h80 | (8'($urandom) & ~DIV_CLEAR_MASK & 8'h7F));
               queue_tick(8'($urandom_range(0, 3)));
            end else begin
               case ($urandom_range(0, 9))
                  0: queue_write(ADDR_IRQ_ACK - 16'd1, 8'($urandom));
                  1: queue_write(ADDR_DIV_CTRL + 16'd1, 8'($urandom));
                  2: queue_write(ADDR_UPDN_HI + 16'd1, 8'($urandom));
                  3: queue_write(ADDR_MODE - 16'd1, 8'($urandom));
                  4: queue_write(ADDR_MODE + 16'd4, 8'($urandom));
                  5: queue_write(ADDR_MODE_FOUR - 16'd1, 8'($urandom));
                  6: queue_write(ROM_BASE - 16'd1, 8'($urandom));
                  7: queue_tick(8'($urandom));
                  default: queue_write(16'($urandom), 8'($urandom));
               endcase
            end
         end
         wait_for_drain();
      end

      repeat (8) @(posedge clock);
      if (expected_maps.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_maps.size()));

      $display("checked %0d bus transfers over %0d power strap settings and all banking modes",
               accepted_count, strap_settings);
      $display("%0d results with irq raised, %0d writes passed through to prg memory",
               irq_results, pass_through);
      if (error_count == 0)
         $display("copier_cart_bank_mapper_with_irq verification clean");
      else
         $display("copier_cart_bank_mapper_with_irq verification failed");
      $finish;
   end

endmodule
